@@ rtl/core/pff_pkg.sv @@
// Shared constants and types for the point force field evaluator.
`timescale 1ns / 1ps
package pff_pkg;
  localparam int FRAC_BITS  = 16;
  localparam int FALL_BITS  = 30;
  localparam int ROOT_STEPS = 38;
  localparam int RAD_W      = 2 * ROOT_STEPS;
  localparam int SQRT_PRE   = 12;
  localparam int ROOT_REM_W = ROOT_STEPS + 4;
  localparam int LD_W       = ROOT_STEPS + 64;
  localparam int DEN_SHIFT  = 24 - FRAC_BITS;
  localparam int DEN_W      = LD_W + DEN_SHIFT + 4;
  localparam int NUM_W      = 124;
  localparam int QUO_W      = 32;
  localparam int DREM_W     = DEN_W + 1;

  localparam logic [63:0] SOFT_Q = 64'(((64'd1 << (2 * FRAC_BITS)) + 64'd50) / 64'd100);

  localparam logic [1:0] MODE_ATTRACT = 2'd0;
  localparam logic [1:0] MODE_REPEL   = 2'd1;
  localparam logic [1:0] MODE_VORTEX  = 2'd2;

  localparam logic [2:0] REG_CX       = 3'd0;
  localparam logic [2:0] REG_CY       = 3'd1;
  localparam logic [2:0] REG_CZ       = 3'd2;
  localparam logic [2:0] REG_STRENGTH = 3'd3;
  localparam logic [2:0] REG_RADIUS   = 3'd4;
  localparam logic [2:0] REG_MODE     = 3'd5;

  typedef struct packed {
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] strength;
    logic [30:0] radius;
    logic [1:0]  mode;
  } pff_cfg_t;

  // kill: zero distance or zero tangent; neg: final sign per component
  typedef struct packed {
    logic       kill;
    logic       k;
    logic [2:0] neg;
  } pff_flags_t;

  typedef struct packed {
    pff_flags_t       flags;
    logic [2:0][30:0] um;
    logic [63:0]      sm;
    logic [63:0]      dsum;
    logic             funl;
    logic             fzero;
  } pff_carry_t;
endpackage

@@ rtl/core/point_force_field_eval.sv @@
// Top level of the point force field evaluator.
`timescale 1ns / 1ps
// Point force field evaluator. Each beat on the slave stream carries one body
// (position and mass, Q16.16) and yields exactly one beat on the master stream
// with the force vector the configured field exerts on it, saturated to signed
// 32 bits, and a clipped flag in tuser. The datapath is a fully pipelined chain
// of 80 register stages, the last being the output register: a new body is
// taken every cycle while the pipeline is not frozen. The depth is set
// by the 38-stage square root of the direction length (the 30-step falloff
// divide runs beside it) and the 33-stage divider (an overflow check, then one
// stage per quotient bit) that forms the three components. When the master side
// stalls, one result waits in the output register and one more in a skid
// register; only when the skid register is full does the whole pipeline freeze
// and s_tready drop. Field registers sit on the APB port at byte addresses
// 0x00 centre x, 0x04 centre y, 0x08 centre z, 0x0C strength, 0x10 radius
// (0 = unlimited reach), 0x14 mode (0 attract, 1 repel, 2 vortex, 3 acts as
// attract). Write them only while no beat is in flight.
module point_force_field_eval (
  input  logic         clk,
  input  logic         rst,
  // APB configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  // body stream
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // body_x, body_y, body_z, body_weight
  // force stream
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [95:0]  m_tdata,  // force_x, force_y, force_z
  output logic [0:0]   m_tuser   // clipped
);
  pff_pkg::pff_cfg_t cfg;
  logic wr_en;
  logic pipe_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        pff_pkg::REG_CX:       cfg.cx       <= pwdata;
        pff_pkg::REG_CY:       cfg.cy       <= pwdata;
        pff_pkg::REG_CZ:       cfg.cz       <= pwdata;
        pff_pkg::REG_STRENGTH: cfg.strength <= pwdata;
        pff_pkg::REG_RADIUS:   cfg.radius   <= pwdata[30:0];
        pff_pkg::REG_MODE:     cfg.mode     <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      pff_pkg::REG_CX:       prdata = cfg.cx;
      pff_pkg::REG_CY:       prdata = cfg.cy;
      pff_pkg::REG_CZ:       prdata = cfg.cz;
      pff_pkg::REG_STRENGTH: prdata = cfg.strength;
      pff_pkg::REG_RADIUS:   prdata = {1'b0, cfg.radius};
      pff_pkg::REG_MODE:     prdata = {30'd0, cfg.mode};
      default:               prdata = '0;
    endcase
  end

  // ---- datapath ----
  logic                f_vld, r_vld, c_vld, d_vld;
  pff_pkg::pff_carry_t f_carry, r_carry;
  logic [63:0]         f_u2, f_r2;
  logic [61:0]         f_rlim2;
  logic [pff_pkg::ROOT_STEPS-1:0] r_len;
  logic [pff_pkg::FALL_BITS-1:0]  r_fq;
  pff_pkg::pff_flags_t c_flags, d_flags;
  logic [2:0][pff_pkg::NUM_W-1:0] c_num;
  logic [pff_pkg::DEN_W-1:0]      c_den;
  logic [2:0][pff_pkg::QUO_W-1:0] d_quo;
  logic [2:0]                     d_over;

  assign s_tready = pipe_en;

  pff_front u_front (
    .clk, .rst, .en(pipe_en), .in_vld(s_tvalid & s_tready),
    .bx(s_tdata[31:0]), .by(s_tdata[63:32]), .bz(s_tdata[95:64]),
    .bw(s_tdata[127:96]), .cfg,
    .out_vld(f_vld), .carry(f_carry), .u2(f_u2), .r2(f_r2), .rlim2(f_rlim2)
  );

  pff_root_fall u_root (
    .clk, .rst, .en(pipe_en), .in_vld(f_vld), .in_carry(f_carry),
    .u2(f_u2), .r2(f_r2), .rlim2(f_rlim2),
    .out_vld(r_vld), .carry(r_carry), .len(r_len), .fq(r_fq)
  );

  pff_scale u_scale (
    .clk, .rst, .en(pipe_en), .in_vld(r_vld), .in_carry(r_carry),
    .len(r_len), .fq(r_fq),
    .out_vld(c_vld), .flags(c_flags), .num(c_num), .den(c_den)
  );

  pff_div u_div (
    .clk, .rst, .en(pipe_en), .in_vld(c_vld), .in_flags(c_flags),
    .num(c_num), .den(c_den),
    .out_vld(d_vld), .flags(d_flags), .quo(d_quo), .over(d_over)
  );

  // ---- saturation and sign ----
  logic [95:0] res_data;
  logic        res_clip;
  always_comb begin
    logic [31:0] lim, mag;
    logic        cl;
    res_clip = 1'b0;
    res_data = '0;
    for (int i = 0; i < 3; i++) begin
      lim = d_flags.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      cl  = d_over[i] || (d_quo[i] > lim);
      mag = cl ? lim : d_quo[i];
      res_data[32*i +: 32] = d_flags.neg[i] ? (~mag + 32'd1) : mag;
      res_clip = res_clip | cl;
    end
    if (d_flags.kill) begin
      res_data = '0;
      res_clip = 1'b0;
    end
  end

  // ---- output register plus skid ----
  logic        skid_vld;
  logic [95:0] skid_data;
  logic        skid_clip;
  logic        take;

  assign pipe_en = ~skid_vld;
  assign take    = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_vld <= 1'b0;
    end else if (skid_vld) begin
      if (take) begin
        skid_vld <= 1'b0;
      end
    end else if (d_vld) begin
      if (m_tvalid && !take) begin
        skid_vld <= 1'b1;
      end else begin
        m_tvalid <= 1'b1;
      end
    end else if (take) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld) begin
      if (take) begin
        m_tdata <= skid_data;
        m_tuser <= skid_clip;
      end
    end else if (d_vld) begin
      if (m_tvalid && !take) begin
        skid_data <= res_data;
        skid_clip <= res_clip;
      end else begin
        m_tdata <= res_data;
        m_tuser <= res_clip;
      end
    end
  end
endmodule

@@ rtl/core/pff_front.sv @@
// Front stages: distance, scaling, squares, softened denominator.
`timescale 1ns / 1ps
module pff_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  logic [31:0]         bx,
  input  logic [31:0]         by,
  input  logic [31:0]         bz,
  input  logic [31:0]         bw,
  input  pff_pkg::pff_cfg_t   cfg,
  output logic                out_vld,
  output pff_pkg::pff_carry_t carry,
  output logic [63:0]         u2,
  output logic [63:0]         r2,
  output logic [61:0]         rlim2
);
  logic v1, v2, v3;
  logic [2:0][32:0] d1;
  logic [63:0] sm1, sm2, sm3;
  logic [2:0][30:0] a2, um3;
  logic [2:0] neg2;
  logic k2, dz2, k3;
  logic [2:0][61:0] sq3;
  logic [61:0] rr3;
  pff_pkg::pff_flags_t fl3;

  logic [31:0] sabs;
  logic [2:0][31:0] dabs;
  logic kk, vort, rep;
  logic [2:0] un;
  logic [2:0][30:0] a_s, um_s;
  logic [63:0] r2_s;

  assign sabs = cfg.strength[31] ? (~cfg.strength + 32'd1) : cfg.strength;
  assign vort = cfg.mode == pff_pkg::MODE_VORTEX;
  assign rep  = cfg.mode == pff_pkg::MODE_REPEL;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dabs[i] = d1[i][32] ? 32'(-d1[i]) : d1[i][31:0];
    end
    kk = dabs[0][31] | dabs[1][31] | dabs[2][31];
    for (int i = 0; i < 3; i++) begin
      a_s[i] = kk ? dabs[i][31:1] : dabs[i][30:0];
    end
    if (vort) begin
      um_s = {a2[0], 31'd0, a2[2]};
      un   = {~neg2[0], 1'b0, neg2[2]};
    end else begin
      um_s = a2;
      un   = rep ? ~neg2 : neg2;
    end
    r2_s = 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v1 <= in_vld;
      v2 <= v1;
      v3 <= v2;
      out_vld <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= {cfg.cx[31], cfg.cx} - {bx[31], bx};
      d1[1] <= {cfg.cy[31], cfg.cy} - {by[31], by};
      d1[2] <= {cfg.cz[31], cfg.cz} - {bz[31], bz};
      sm1   <= sabs * bw;
      // magnitudes with common scaling
      a2   <= a_s;
      neg2 <= {d1[2][32], d1[1][32], d1[0][32]};
      k2   <= kk;
      dz2  <= (d1[0] == 33'd0) && (d1[1] == 33'd0) && (d1[2] == 33'd0);
      sm2  <= sm1;
      // squares and direction
      for (int i = 0; i < 3; i++) sq3[i] <= a2[i] * a2[i];
      rr3  <= cfg.radius * cfg.radius;
      um3  <= um_s;
      fl3.kill <= dz2 | (vort && (a2[0] == 31'd0) && (a2[2] == 31'd0));
      fl3.k    <= k2;
      fl3.neg  <= un ^ {3{cfg.strength[31]}};
      k3   <= k2;
      sm3  <= sm2;
      // sums and falloff select
      r2    <= r2_s;
      u2    <= vort ? (64'(sq3[0]) + 64'(sq3[2])) : r2_s;
      rlim2 <= rr3;
      carry.flags <= fl3;
      carry.um    <= um3;
      carry.sm    <= sm3;
      carry.dsum  <= r2_s + (k3 ? (pff_pkg::SOFT_Q >> 2) : pff_pkg::SOFT_Q);
      carry.funl  <= cfg.radius == 31'd0;
      carry.fzero <= (cfg.radius != 31'd0) && (k3 || (r2_s >= 64'(rr3)));
    end
  end
endmodule

@@ rtl/core/pff_root_fall.sv @@
// Pipelined square root of the direction length and falloff quotient.
`timescale 1ns / 1ps
module pff_root_fall (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  pff_pkg::pff_carry_t in_carry,
  input  logic [63:0]         u2,
  input  logic [63:0]         r2,
  input  logic [61:0]         rlim2,
  output logic                out_vld,
  output pff_pkg::pff_carry_t carry,
  output logic [pff_pkg::ROOT_STEPS-1:0] len,
  output logic [pff_pkg::FALL_BITS-1:0]  fq
);
  localparam int N  = pff_pkg::ROOT_STEPS;
  localparam int RW = pff_pkg::ROOT_REM_W;
  localparam int XW = pff_pkg::RAD_W;
  localparam int FB = pff_pkg::FALL_BITS;

  logic [N:0]          vld;
  logic [XW-1:0]       rad  [N+1];
  logic [N-1:0]        root [N+1];
  logic [RW-1:0]       rrem [N+1];
  logic [63:0]         frem [N+1];
  logic [FB-1:0]       fqt  [N+1];
  logic [61:0]         lim  [N+1];
  pff_pkg::pff_carry_t cr   [N+1];

  assign vld[0]  = in_vld;
  assign rad[0]  = {u2, {pff_pkg::SQRT_PRE{1'b0}}};
  assign root[0] = '0;
  assign rrem[0] = '0;
  assign frem[0] = r2;
  assign fqt[0]  = '0;
  assign lim[0]  = rlim2;
  assign cr[0]   = in_carry;

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [RW-1:0] t, trial;
    logic ge;
    assign t     = {rrem[j][RW-3:0], rad[j][XW-1 -: 2]};
    assign trial = RW'({root[j], 2'b01});
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[j+1]  <= rad[j] << 2;
        root[j+1] <= {root[j][N-2:0], ge};
        rrem[j+1] <= ge ? (t - trial) : t;
        lim[j+1]  <= lim[j];
        cr[j+1]   <= cr[j];
      end
    end

    if (j < FB) begin : g_fall
      logic [63:0] ft;
      logic fge;
      assign ft  = {frem[j][62:0], 1'b0};
      assign fge = ft >= 64'(lim[j]);
      always_ff @(posedge clk) begin
        if (en) begin
          frem[j+1] <= fge ? (ft - 64'(lim[j])) : ft;
          fqt[j+1]  <= {fqt[j][FB-2:0], fge};
        end
      end
    end else begin : g_hold
      always_ff @(posedge clk) begin
        if (en) begin
          frem[j+1] <= frem[j];
          fqt[j+1]  <= fqt[j];
        end
      end
    end
  end

  assign out_vld = vld[N];
  assign carry   = cr[N];
  assign len     = root[N];
  assign fq      = fqt[N];
endmodule

@@ rtl/core/pff_scale.sv @@
// Multiply stages: falloff times direction, strength-mass product, denominator.
`timescale 1ns / 1ps
module pff_scale (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  pff_pkg::pff_carry_t in_carry,
  input  logic [pff_pkg::ROOT_STEPS-1:0] len,
  input  logic [pff_pkg::FALL_BITS-1:0]  fq,
  output logic                out_vld,
  output pff_pkg::pff_flags_t flags,
  output logic [2:0][pff_pkg::NUM_W-1:0] num,
  output logic [pff_pkg::DEN_W-1:0]      den
);
  localparam int FB = pff_pkg::FALL_BITS;

  logic vb, vc, vd;
  pff_pkg::pff_flags_t fb, fc, fd;
  logic [2:0][61:0] fub, fuc;
  logic [63:0] smb, smc;
  logic [63:0] ll, lh0, hl0, hh0;
  logic [2:0][3:0][63:0] pp;
  logic [FB:0] f;
  logic [pff_pkg::LD_W-1:0] ldsum;
  logic [pff_pkg::DEN_W-1:0] denc, dend;

  always_comb begin
    if (in_carry.fzero) f = '0;
    else if (in_carry.funl) f = (FB+1)'(1) << FB;
    else f = ((FB+1)'(1) << FB) - (FB+1)'(fq);
  end

  assign ldsum = (pff_pkg::LD_W'(hh0) << 64) + (pff_pkg::LD_W'(lh0) << 32)
               + (pff_pkg::LD_W'(hl0) << 32) + pff_pkg::LD_W'(ll);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
      vd <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      vb <= in_vld;
      vc <= vb;
      vd <= vc;
      out_vld <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) fub[i] <= f * in_carry.um[i];
      hh0 <= 64'(len[pff_pkg::ROOT_STEPS-1:32]) * 64'(in_carry.dsum[63:32]);
      hl0 <= 64'(len[pff_pkg::ROOT_STEPS-1:32]) * 64'(in_carry.dsum[31:0]);
      lh0 <= len[31:0] * in_carry.dsum[63:32];
      ll  <= len[31:0] * in_carry.dsum[31:0];
      smb <= in_carry.sm;
      fb  <= in_carry.flags;
      // scaled denominator
      denc <= fb.k ? (pff_pkg::DEN_W'(ldsum) << (pff_pkg::DEN_SHIFT + 2))
                   : (pff_pkg::DEN_W'(ldsum) << pff_pkg::DEN_SHIFT);
      fuc <= fub;
      smc <= smb;
      fc  <= fb;
      // numerator partial products
      for (int i = 0; i < 3; i++) begin
        pp[i][3] <= smc[63:32] * 32'(fuc[i][61:32]);
        pp[i][2] <= smc[63:32] * fuc[i][31:0];
        pp[i][1] <= smc[31:0] * 32'(fuc[i][61:32]);
        pp[i][0] <= smc[31:0] * fuc[i][31:0];
      end
      fd   <= fc;
      dend <= denc;
      for (int i = 0; i < 3; i++) begin
        num[i] <= pff_pkg::NUM_W'((128'(pp[i][3]) << 64) + (128'(pp[i][2]) << 32)
                                + (128'(pp[i][1]) << 32) + 128'(pp[i][0]));
      end
      flags <= fd;
      // den is formed in denc, ahead of num; dend and den delay it to stay aligned
      den   <= dend;
    end
  end
endmodule

@@ rtl/core/pff_div.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pff_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_vld,
  input  pff_pkg::pff_flags_t in_flags,
  input  logic [2:0][pff_pkg::NUM_W-1:0] num,
  input  logic [pff_pkg::DEN_W-1:0]      den,
  output logic                out_vld,
  output pff_pkg::pff_flags_t flags,
  output logic [2:0][pff_pkg::QUO_W-1:0] quo,
  output logic [2:0]          over
);
  localparam int N  = pff_pkg::QUO_W;
  localparam int RW = pff_pkg::DREM_W;
  localparam int DW = pff_pkg::DEN_W;

  logic [N:0]          vld;
  pff_pkg::pff_flags_t fl  [N+1];
  logic [DW-1:0]       dn  [N+1];
  logic [2:0]          ov  [N+1];
  logic [2:0][RW-1:0]  rm  [N+1];
  logic [2:0][N-1:0]   lw  [N+1];

  // entry stage: overflow check and initial partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fl[0] <= in_flags;
      dn[0] <= den;
      for (int i = 0; i < 3; i++) begin
        ov[0][i] <= DW'(num[i][pff_pkg::NUM_W-1:N]) >= den;
        rm[0][i] <= RW'(num[i][pff_pkg::NUM_W-1:N]);
        lw[0][i] <= num[i][N-1:0];
      end
    end
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [2:0][RW-1:0] t;
    logic [2:0] ge;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        t[i]  = {rm[j][i][RW-2:0], lw[j][i][N-1]};
        ge[i] = t[i] >= RW'(dn[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        fl[j+1] <= fl[j];
        dn[j+1] <= dn[j];
        ov[j+1] <= ov[j];
        for (int i = 0; i < 3; i++) begin
          rm[j+1][i] <= ge[i] ? (t[i] - RW'(dn[j])) : t[i];
          lw[j+1][i] <= {lw[j][i][N-2:0], ge[i]};
        end
      end
    end
  end

  assign out_vld = vld[N];
  assign flags   = fl[N];
  assign quo     = lw[N];
  assign over    = ov[N];
endmodule

@@ rtl/core/pff_chk.sv @@
// Port-level checks for the point force field evaluator.
`timescale 1ns / 1ps
module pff_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [0:0]  m_tuser
);
  // skid fills only behind a held output beat
  a_stall_implies_out: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid) else $error("input stalled with no output beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid) else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("output beat dropped");

  a_clip_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata != 96'd0)
    else $error("clipped beat with zero force");
endmodule

bind point_force_field_eval pff_chk u_pff_chk (
  .clk(clk), .rst(rst), .s_tready(s_tready), .m_tvalid(m_tvalid),
  .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
